FILE: hdl/lfu_pkg.sv
package lfu_pkg;

	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_COUNT_BITS = 16;
	localparam int DATA_BITS      = 32;
	localparam int CAP_BITS       = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	typedef struct packed {
		logic                        kind;
		logic signed [DATA_BITS-1:0] key;
		logic signed [DATA_BITS-1:0] value;
	} lfu_in_t;

	typedef struct packed {
		logic                        hit;
		logic signed [DATA_BITS-1:0] read_value;
	} lfu_out_t;

	// move: pull the slot out of the recency order and put it on top
	// fill: a free slot becomes valid and goes on top
	typedef struct packed {
		logic move;
		logic fill;
	} lfu_rank_cmd_t;

endpackage

FILE: hdl/lfu_mem.sv
module lfu_mem #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [IW-1:0]                   wr_addr,
	input  logic [lfu_pkg::DATA_BITS-1:0]   wr_key,
	input  logic [lfu_pkg::DATA_BITS-1:0]   wr_val,
	input  logic [COUNT_BITS-1:0]           wr_cnt,
	input  logic                            rd_en,
	input  logic [IW-1:0]                   rd_addr,
	output logic [lfu_pkg::DATA_BITS-1:0]   rd_key,
	output logic [lfu_pkg::DATA_BITS-1:0]   rd_val,
	output logic [COUNT_BITS-1:0]           rd_cnt
);
	import lfu_pkg::*;

	logic [DATA_BITS-1:0]  key_mem [ENTRIES];
	logic [DATA_BITS-1:0]  val_mem [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
			cnt_mem[wr_addr] <= wr_cnt;
		end
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_val <= val_mem[rd_addr];
			rd_cnt <= cnt_mem[rd_addr];
		end
	end

endmodule

FILE: hdl/lfu_rank.sv
module lfu_rank #(
	parameter int ENTRIES = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int RW = IW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lfu_pkg::lfu_rank_cmd_t cmd,
	input  logic [IW-1:0]          slot,
	input  logic [RW-1:0]          sel_rank,
	input  logic [RW-1:0]          new_rank,
	input  logic [IW-1:0]          rd_idx,
	output logic                   rd_valid,
	output logic [RW-1:0]          rd_rank
);
	import lfu_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [RW-1:0]      rank_q [ENTRIES];

	assign rd_valid = valid_q[rd_idx];
	assign rd_rank  = rank_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.fill) begin
			valid_q[slot] <= 1'b1;
		end
	end

	// each entry above the moved one steps down; the moved one goes on top
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.move && valid_q[i] && (IW'(i) != slot) && (rank_q[i] > sel_rank)) begin
				rank_q[i] <= rank_q[i] - RW'(1);
			end
		end
		if (cmd.move || cmd.fill) begin
			rank_q[slot] <= new_rank;
		end
	end

endmodule

FILE: hdl/lfu_cache_table_top.sv
// LFU key/value table with least-recently-touched tie break.
// Input channel (in_valid/in_stall/in_item): one get or put per item. An item
// is taken when in_valid is high and in_stall is low; in_stall stays high while
// an item is being worked on.
// Output channel (out_valid/out_stall/out_item): one result item per input item,
// held in an output register until out_stall is low, so a waiting result does
// not keep the next item from being taken and scanned.
// Each item scans every entry of the key/value/count RAM, one entry a cycle
// through its single read port, looking for the key, the first free entry and
// the least used entry at once; the S_UPD state then writes back the entry and
// updates the recency ranks.
// The block takes no new item until the last one has been written back, and a
// held result delays the write-back of the next item until the output register
// frees. Capacity is written on cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Reset clears all valid bits and the occupancy and sets capacity to 16;
// no clearing pass is needed, the block takes an item right after reset.
module lfu_cache_table_top #(
	parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
	parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lfu_pkg::lfu_in_t              in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lfu_pkg::lfu_out_t             out_item
);
	import lfu_pkg::*;

	localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW  = IW;
	localparam int OW  = $clog2(ENTRIES + 1);
	localparam int CPW = (OW > CAP_BITS) ? OW : CAP_BITS;
	localparam logic [IW-1:0]         LAST_IDX  = IW'(ENTRIES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q;

	logic [CAP_BITS-1:0] capacity_q;
	logic [OW-1:0]       occ_q;
	lfu_in_t             op_q;

	logic          issue_q;
	logic [IW-1:0] rd_idx_q;
	logic          eval_s1;
	logic [IW-1:0] idx_s1;

	logic                  found_q;
	logic [IW-1:0]         hit_slot_q;
	logic [RW-1:0]         hit_rank_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [DATA_BITS-1:0]  hit_val_q;

	logic                  have_q;
	logic [IW-1:0]         vic_slot_q;
	logic [RW-1:0]         vic_rank_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;

	logic          free_have_q;
	logic [IW-1:0] free_slot_q;

	logic                 out_valid_q;
	lfu_out_t             out_q;

	logic [DATA_BITS-1:0]  rd_key, rd_val;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic                  rk_valid;
	logic [RW-1:0]         rk_rank;

	logic                  upd_go;
	logic                  mem_we;
	logic [IW-1:0]         wr_addr;
	logic [DATA_BITS-1:0]  wr_val;
	logic [COUNT_BITS-1:0] wr_cnt;
	lfu_rank_cmd_t         rk_cmd;
	logic [RW-1:0]         sel_rank, new_rank;
	logic                  occ_inc;
	lfu_out_t              res;

	logic [CPW-1:0]        cap_eff;
	logic [COUNT_BITS-1:0] hit_cnt_inc;
	logic                  match, better;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign cap_eff = (CPW'(capacity_q) > CPW'(ENTRIES)) ? CPW'(ENTRIES) : CPW'(capacity_q);
	assign hit_cnt_inc = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);

	assign match  = rk_valid && (rd_key == op_q.key);
	assign better = rk_valid && (!have_q || (rd_cnt < vic_cnt_q) ||
		((rd_cnt == vic_cnt_q) && (rk_rank < vic_rank_q)));

	assign upd_go = (state_q == S_UPD) && !(out_valid_q && out_stall);

	lfu_mem #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (wr_addr),
		.wr_key  (op_q.key),
		.wr_val  (wr_val),
		.wr_cnt  (wr_cnt),
		.rd_en   (issue_q),
		.rd_addr (rd_idx_q),
		.rd_key  (rd_key),
		.rd_val  (rd_val),
		.rd_cnt  (rd_cnt)
	);

	lfu_rank #(
		.ENTRIES (ENTRIES)
	) u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (rk_cmd),
		.slot     (wr_addr),
		.sel_rank (sel_rank),
		.new_rank (new_rank),
		.rd_idx   (idx_s1),
		.rd_valid (rk_valid),
		.rd_rank  (rk_rank)
	);

	// write-back decision, applied only on upd_go
	always_comb begin
		mem_we   = 1'b0;
		wr_addr  = hit_slot_q;
		wr_val   = op_q.value;
		wr_cnt   = hit_cnt_inc;
		rk_cmd   = '0;
		sel_rank = hit_rank_q;
		new_rank = RW'(occ_q - OW'(1));
		occ_inc  = 1'b0;
		res      = '0;
		if (upd_go) begin
			if (op_q.kind == KIND_GET) begin
				if (found_q) begin
					res.hit        = 1'b1;
					res.read_value = hit_val_q;
					mem_we         = 1'b1;
					wr_val         = hit_val_q;
					rk_cmd.move    = 1'b1;
				end
			end else if (cap_eff != '0) begin
				if (found_q) begin
					res.hit     = 1'b1;
					mem_we      = 1'b1;
					rk_cmd.move = 1'b1;
				end else if (CPW'(occ_q) < cap_eff) begin
					mem_we      = 1'b1;
					wr_addr     = free_slot_q;
					wr_cnt      = COUNT_BITS'(1);
					rk_cmd.fill = 1'b1;
					new_rank    = RW'(occ_q);
					occ_inc     = 1'b1;
				end else begin
					mem_we      = 1'b1;
					wr_addr     = vic_slot_q;
					wr_cnt      = COUNT_BITS'(1);
					rk_cmd.move = 1'b1;
					sel_rank    = vic_rank_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			capacity_q  <= CAP_RESET;
			occ_q       <= '0;
			issue_q     <= 1'b0;
			eval_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (occ_inc) begin
				occ_q <= occ_q + OW'(1);
			end
			eval_s1 <= issue_q;
			if (issue_q && (rd_idx_q == LAST_IDX)) begin
				issue_q <= 1'b0;
			end
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						issue_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (eval_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture, scan address and search trackers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			op_q        <= in_item;
			rd_idx_q    <= '0;
			found_q     <= 1'b0;
			have_q      <= 1'b0;
			free_have_q <= 1'b0;
		end else begin
			if (issue_q && (rd_idx_q != LAST_IDX)) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (eval_s1) begin
				if (match && !found_q) begin
					found_q    <= 1'b1;
					hit_slot_q <= idx_s1;
					hit_rank_q <= rk_rank;
					hit_cnt_q  <= rd_cnt;
					hit_val_q  <= rd_val;
				end
				if (better) begin
					have_q     <= 1'b1;
					vic_slot_q <= idx_s1;
					vic_rank_q <= rk_rank;
					vic_cnt_q  <= rd_cnt;
				end
				if (!rk_valid && !free_have_q) begin
					free_have_q <= 1'b1;
					free_slot_q <= idx_s1;
				end
			end
		end
		idx_s1 <= rd_idx_q;
		if (upd_go) begin
			out_q <= res;
		end
	end

endmodule

FILE: sim/lfu_checker.sv
`timescale 1ns / 1ps

module lfu_checker #(
	parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
	parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  lfu_pkg::lfu_in_t              in_item,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  lfu_pkg::lfu_out_t             out_item,
	output int                            fail_count,
	output int                            pending
);

	import lfu_pkg::*;

	logic                  row_valid [ENTRIES];
	logic [DATA_BITS-1:0]  row_key   [ENTRIES];
	logic [DATA_BITS-1:0]  row_value [ENTRIES];
	logic [COUNT_BITS-1:0] row_count [ENTRIES];
	int                    row_rank  [ENTRIES];
	int                    occupancy;
	logic [CAP_BITS-1:0]   capacity;

	lfu_out_t due_replies [$];
	int       errors;

	// everything above slot s in the recency order moves down one
	function automatic void lower_ranks_above(int s);
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (row_valid[i] && i != s && row_rank[i] > row_rank[s])
				row_rank[i]--;
	endfunction

	function automatic void bump(int s);
		lower_ranks_above(s);
		row_rank[s] = occupancy - 1;
		if (row_count[s] != '1)
			row_count[s]++;
	endfunction

	function automatic lfu_out_t lfu_apply(lfu_in_t it);
		lfu_out_t r;
		int       eff_cap;
		int       slot;
		int       i;
		bit       found;
		bit       have;
		r       = '0;
		eff_cap = (int'(capacity) < ENTRIES) ? int'(capacity) : ENTRIES;
		found   = 1'b0;
		have    = 1'b0;
		slot    = 0;
		for (i = 0; i < ENTRIES; i++)
			if (!found && row_valid[i] && row_key[i] == it.key) begin
				found = 1'b1;
				slot  = i;
			end

		if (it.kind == KIND_GET) begin
			if (found) begin
				r.hit        = 1'b1;
				r.read_value = row_value[slot];
				bump(slot);
			end
			return r;
		end

		// zero capacity: puts are dropped, even on a present key
		if (eff_cap == 0)
			return r;

		if (found) begin
			r.hit           = 1'b1;
			row_value[slot] = it.value;
			bump(slot);
			return r;
		end

		if (occupancy < eff_cap) begin
			for (i = ENTRIES - 1; i >= 0; i--)
				if (!row_valid[i])
					slot = i;
			occupancy++;
		end else begin
			// lowest count, ties to the least recent
			for (i = 0; i < ENTRIES; i++) begin
				if (!row_valid[i])
					continue;
				if (!have || row_count[i] < row_count[slot] ||
				    (row_count[i] == row_count[slot] && row_rank[i] < row_rank[slot])) begin
					slot = i;
					have = 1'b1;
				end
			end
			lower_ranks_above(slot);
		end

		row_valid[slot] = 1'b1;
		row_key[slot]   = it.key;
		row_value[slot] = it.value;
		row_count[slot] = COUNT_BITS'(1);
		row_rank[slot]  = occupancy - 1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lfu_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				row_valid[i] = 1'b0;
			occupancy = 0;
			capacity  = CAP_RESET;
			errors    = 0;
			due_replies.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_replies.size() == 0) begin
					$error("result with nothing outstanding: hit %0b read_value %0d",
						out_item.hit, out_item.read_value);
					errors++;
				end else begin
					want = due_replies.pop_front();
					if (out_item.hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, out_item.hit);
						errors++;
					end
					if (out_item.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, out_item.read_value);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				due_replies.push_back(lfu_apply(in_item));
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			pending    <= due_replies.size();
			fail_count <= errors;
		end
	end

endmodule

FILE: sim/tb_lfu_cache_table_top.sv
`timescale 1ns / 1ps

module tb_lfu_cache_table_top;

	import lfu_pkg::*;

	localparam int ENTRIES    = 16;
	// narrow counts so that saturation and count ties come up often
	localparam int COUNT_BITS = 3;
	localparam int POOL       = 24;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CAP_BITS-1:0] cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	lfu_in_t             in_item;
	logic                out_valid;
	logic                out_stall;
	lfu_out_t            out_item;
	int                  fail_count;
	int                  pending;

	logic [DATA_BITS-1:0] key_pool [POOL];
	int                   pool_size;
	bit                   burst;
	bit                   hold_req;

	lfu_cache_table_top #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

	lfu_checker #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send(logic kind, logic [DATA_BITS-1:0] key, logic [DATA_BITS-1:0] value);
		in_item  <= '{kind: kind, key: key, value: value};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic sender_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (burst || r < 45)
			n = 0;
		else if (r < 85)
			n = $urandom_range(1, 4);
		else if (r < 97)
			n = $urandom_range(5, 24);
		else
			n = $urandom_range(30, 90);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (ENTRIES + 6) @(posedge clk);
	endtask

	task automatic set_capacity(int cap);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CAP_BITS'(cap);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [DATA_BITS-1:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	function automatic logic [DATA_BITS-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// receiver: mostly ready, short and occasional long stalls, one long hold on request
	initial begin : receiver
		int r;
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				r = $urandom_range(0, 9);
				if (r < 6)
					n = 0;
				else if (r < 9)
					n = $urandom_range(1, 3);
				else
					n = $urandom_range(10, 40);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int caps [13];
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_item     = '0;
		out_stall   = 1'b0;
		burst       = 1'b0;
		hold_req    = 1'b0;
		caps = '{1, 0, 2, 31, 4, 17, 3, 0, 8, 16, 2, 5, 12};
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		key_pool[4] = 32'h0000_0001;
		for (int i = 5; i < POOL; i++)
			key_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty miss, extreme keys and values, update, saturation
		send(KIND_GET, 32'h0000_0000, 32'h0000_0000);
		send(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
		sender_gap();
		send(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
		send(KIND_GET, 32'h8000_0000, 32'h1234_5678);
		sender_gap();
		send(KIND_PUT, 32'h8000_0000, 32'h0000_0000);
		send(KIND_GET, 32'h8000_0000, 32'hffff_ffff);
		send(KIND_GET, 32'h0000_0001, 32'h0000_0000);
		repeat (9) begin
			send(KIND_GET, 32'h7fff_ffff, 32'h0000_0000);
			sender_gap();
		end
		send(KIND_GET, 32'hffff_ffff, 32'h0000_0000);
		send(KIND_GET, 32'h0000_0000, 32'h0000_0000);

		foreach (caps[p]) begin
			set_capacity(caps[p]);
			pool_size = $urandom_range(3, POOL);
			burst     = (p % 4 == 1) || (p == 3);
			if (p == 3)
				hold_req = 1'b1;
			repeat (110) begin
				send(1'($urandom_range(0, 1)), pick_key(), pick_value());
				sender_gap();
			end
		end

		drain();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hdl/lfu_pkg.sv
hdl/lfu_mem.sv
hdl/lfu_rank.sv
hdl/lfu_cache_table_top.sv
sim/lfu_checker.sv
sim/tb_lfu_cache_table_top.sv
